### design/shamh_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and constant tables for the SHA-256 message hasher.
// No dependencies; shamh_round and the top level refer to it by scoped names.
package shamh_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned BlkWords  = 16;
  localparam int unsigned HashWords = 8;
  localparam int unsigned Rounds    = 64;
  localparam int unsigned LenByte   = 56;
  localparam int unsigned LenHiWord = 14;
  localparam int unsigned LenLoWord = 15;
  localparam logic [7:0]  PadByte   = 8'h80;

  typedef logic [WordW-1:0] word_t;

  // Control handed from the sequencer to the round datapath.
  typedef struct packed {
    logic       shift;
    logic       round;
    logic [5:0] rnd;
  } rnd_ctl_t;

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t v;
    case (idx)
      3'd0:    v = 32'h6A09E667;
      3'd1:    v = 32'hBB67AE85;
      3'd2:    v = 32'h3C6EF372;
      3'd3:    v = 32'hA54FF53A;
      3'd4:    v = 32'h510E527F;
      3'd5:    v = 32'h9B05688C;
      3'd6:    v = 32'h1F83D9AB;
      3'd7:    v = 32'h5BE0CD19;
      default: v = 32'h6A09E667;
    endcase
    return v;
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t v;
    case (t)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
      default: v = 32'h428a2f98;
    endcase
    return v;
  endfunction

endpackage

### design/shamh_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module shamh_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata_r
);

  logic [Width-1:0] mem_r [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

### design/shamh_round.sv
`timescale 1ns / 1ps
// SHA-256 round datapath: working variables a..h and the 16-word schedule window.
// Depends on shamh_pkg for the word type, control struct and round constants.
module shamh_round (
  input  logic               clk,
  input  shamh_pkg::rnd_ctl_t ctl,
  input  shamh_pkg::word_t   shift_in,
  input  shamh_pkg::word_t   blk_word,
  output shamh_pkg::word_t   var_head
);

  function automatic shamh_pkg::word_t rotr(input shamh_pkg::word_t x, input int unsigned n);
    return shamh_pkg::word_t'((x >> n) | (x << (shamh_pkg::WordW - n)));
  endfunction

  shamh_pkg::word_t a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  shamh_pkg::word_t w_r [shamh_pkg::BlkWords];
  shamh_pkg::word_t w_nxt, t1, t2, ssig0, ssig1, bsig0, bsig1;

  always_comb begin
    ssig1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    ssig0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    if (ctl.rnd < 6'(shamh_pkg::BlkWords)) begin
      w_nxt = blk_word;
    end else begin
      w_nxt = ssig1 + w_r[9] + ssig0 + w_r[0];
    end
    bsig1 = rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25);
    bsig0 = rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22);
    t1 = h_r + bsig1 + ((e_r & f_r) ^ (~e_r & g_r)) + shamh_pkg::round_k(ctl.rnd) + w_nxt;
    t2 = bsig0 + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
  end

  assign var_head = a_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      // Words enter at h and leave from a, both for loading and for folding.
      a_r <= b_r;
      b_r <= c_r;
      c_r <= d_r;
      d_r <= e_r;
      e_r <= f_r;
      f_r <= g_r;
      g_r <= h_r;
      h_r <= shift_in;
    end else if (ctl.round) begin
      h_r <= g_r;
      g_r <= f_r;
      f_r <= e_r;
      e_r <= d_r + t1;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= a_r;
      a_r <= t1 + t2;
      for (int i = 0; i < shamh_pkg::BlkWords - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[shamh_pkg::BlkWords-1] <= w_nxt;
    end
  end

endmodule

### design/sha256_message_hasher_core.sv
`timescale 1ns / 1ps
// Top level of the SHA-256 message hasher: sequencer, block and chain memories.
// Depends on shamh_pkg, shamh_ram and shamh_round.
//
// Usage: message bytes enter on the in_ channel, one per transfer, with
// in_has_byte set. The transfer that carries in_end_of_message closes the
// message; an empty message is a single transfer with in_has_byte clear and
// in_end_of_message set. A transfer with both flags clear is ignored.
// The out_ channel then delivers the eight digest words, word 0 (most
// significant) first, with out_last_word set on word 7.
//
// Timing: a byte that does not complete a 64-byte block is taken while the
// sequencer stays idle. The 64th byte starts a compression that keeps
// in_ready low: it reads the chaining words from the chain memory, runs 64
// rounds at one round per cycle, and folds the result back into the same
// memory. The final transfer adds up to 16 padding words written into the
// block memory, one or two compressions, then each digest word is read
// through the chain memory's read port and loaded into the output register.
//
// Reset clears all control state; the chaining words then read as the
// standard initial hash values through per-word valid bits, so no clearing
// pass is needed. A stalled receiver holds the digest in the output
// register and the sequencer waits; input is accepted again after word 7
// has been loaded, even while that word is still waiting to be taken.
module sha256_message_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LOAD,
    S_ROUND,
    S_FOLD,
    S_EMIT_RD,
    S_EMIT_WR
  } state_t;

  localparam int unsigned BlkAw  = $clog2(shamh_pkg::BlkWords);
  localparam int unsigned HashAw = $clog2(shamh_pkg::HashWords);

  state_t            state_r;
  logic [5:0]        cnt_r;
  logic [5:0]        fill_r;
  logic [23:0]       acc_r;
  logic [63:0]       bitlen_r;
  logic              fin_r;
  logic              mark_r;
  logic              len_r;
  logic [BlkAw-1:0]  pad_idx_r;
  logic [shamh_pkg::HashWords-1:0] hv_r;
  logic [HashAw-1:0] ch_addr_q_r;
  logic              ch_vld_q_r;
  logic [HashAw-1:0] emit_idx_r;
  logic              out_valid_r;
  shamh_pkg::word_t  out_word_r;
  logic [2:0]        out_index_r;
  logic              out_last_r;

  logic              in_fire;
  logic [5:0]        pos;
  logic              cnt_at_end;

  logic              blk_we, blk_re;
  logic [BlkAw-1:0]  blk_waddr, blk_raddr;
  shamh_pkg::word_t  blk_wdata, blk_rdata, pad_word;

  logic              ch_we, ch_re;
  logic [HashAw-1:0] ch_waddr, ch_raddr;
  shamh_pkg::word_t  ch_wdata, ch_rdata, chain_q;

  shamh_pkg::rnd_ctl_t rctl;
  shamh_pkg::word_t    var_head;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid & in_ready;
  assign pos        = fill_r + 6'(in_has_byte);
  assign cnt_at_end = (cnt_r == 6'(shamh_pkg::HashWords));

  // Unwritten chaining words read as the initial hash values.
  assign chain_q = ch_vld_q_r ? ch_rdata : shamh_pkg::init_hash(ch_addr_q_r);

  // Padding word: the 0x80 marker after any pending bytes, the bit length
  // in the last two words of the length block, zeros elsewhere.
  always_comb begin
    pad_word = '0;
    if (mark_r) begin
      case (fill_r[1:0])
        2'd0:    pad_word = {shamh_pkg::PadByte, 24'h0};
        2'd1:    pad_word = {acc_r[7:0], shamh_pkg::PadByte, 16'h0};
        2'd2:    pad_word = {acc_r[15:0], shamh_pkg::PadByte, 8'h0};
        2'd3:    pad_word = {acc_r[23:0], shamh_pkg::PadByte};
        default: pad_word = '0;
      endcase
    end else if (len_r && pad_idx_r == BlkAw'(shamh_pkg::LenHiWord)) begin
      pad_word = bitlen_r[63:32];
    end else if (len_r && pad_idx_r == BlkAw'(shamh_pkg::LenLoWord)) begin
      pad_word = bitlen_r[31:0];
    end
  end

  always_comb begin
    blk_we    = 1'b0;
    blk_waddr = fill_r[5:2];
    blk_wdata = {acc_r, in_msg_byte};
    if (state_r == S_IDLE) begin
      blk_we = in_fire & in_has_byte & (fill_r[1:0] == 2'b11);
    end else if (state_r == S_PAD) begin
      blk_we    = 1'b1;
      blk_waddr = pad_idx_r;
      blk_wdata = pad_word;
    end
    blk_re    = ((state_r == S_LOAD) && cnt_at_end) ||
                ((state_r == S_ROUND) && (cnt_r < 6'(shamh_pkg::BlkWords - 1)));
    blk_raddr = (state_r == S_ROUND) ? cnt_r[BlkAw-1:0] + BlkAw'(1) : '0;
  end

  always_comb begin
    ch_re    = ((state_r == S_LOAD) || (state_r == S_FOLD)) && !cnt_at_end &&
               (cnt_r < 6'(shamh_pkg::HashWords));
    ch_raddr = cnt_r[HashAw-1:0];
    if (state_r == S_EMIT_RD) begin
      ch_re    = 1'b1;
      ch_raddr = emit_idx_r;
    end
    ch_we    = (state_r == S_FOLD) && (cnt_r != '0);
    ch_waddr = HashAw'(cnt_r - 6'd1);
    ch_wdata = chain_q + var_head;
  end

  always_comb begin
    rctl.shift = ((state_r == S_LOAD) || (state_r == S_FOLD)) && (cnt_r != '0);
    rctl.round = (state_r == S_ROUND);
    rctl.rnd   = cnt_r;
  end

  shamh_ram #(
    .Width (shamh_pkg::WordW),
    .Depth (shamh_pkg::BlkWords)
  ) u_blk_ram (
    .clk     (clk),
    .we      (blk_we),
    .waddr   (blk_waddr),
    .wdata   (blk_wdata),
    .re      (blk_re),
    .raddr   (blk_raddr),
    .rdata_r (blk_rdata)
  );

  shamh_ram #(
    .Width (shamh_pkg::WordW),
    .Depth (shamh_pkg::HashWords)
  ) u_chain_ram (
    .clk     (clk),
    .we      (ch_we),
    .waddr   (ch_waddr),
    .wdata   (ch_wdata),
    .re      (ch_re),
    .raddr   (ch_raddr),
    .rdata_r (ch_rdata)
  );

  shamh_round u_round (
    .clk      (clk),
    .ctl      (rctl),
    .shift_in (chain_q),
    .blk_word (blk_rdata),
    .var_head (var_head)
  );

  always_ff @(posedge clk) begin
    if (ch_re) begin
      ch_addr_q_r <= ch_raddr;
      ch_vld_q_r  <= hv_r[ch_raddr];
    end
    if (in_fire && in_has_byte) begin
      acc_r <= {acc_r[15:0], in_msg_byte};
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      bitlen_r    <= '0;
      fin_r       <= 1'b0;
      mark_r      <= 1'b0;
      len_r       <= 1'b0;
      pad_idx_r   <= '0;
      hv_r        <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_EMIT_WR the output register is reloaded below instead.
      if (out_valid_r && out_ready && (state_r != S_EMIT_WR)) begin
        out_valid_r <= 1'b0;
      end
      if (ch_we) begin
        hv_r[ch_waddr] <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            fin_r  <= in_end_of_message;
            mark_r <= in_end_of_message;
            fill_r <= pos;
            if (in_has_byte) begin
              bitlen_r <= bitlen_r + 64'd8;
            end
            if (in_has_byte && fill_r == 6'd63) begin
              state_r <= S_LOAD;
              cnt_r   <= '0;
              len_r   <= 1'b0;
            end else if (in_end_of_message) begin
              state_r   <= S_PAD;
              pad_idx_r <= pos[5:2];
              len_r     <= (pos < 6'(shamh_pkg::LenByte));
            end
          end
        end
        S_PAD: begin
          mark_r <= 1'b0;
          if (pad_idx_r == BlkAw'(shamh_pkg::BlkWords - 1)) begin
            state_r <= S_LOAD;
            cnt_r   <= '0;
            fill_r  <= '0;
          end else begin
            pad_idx_r <= pad_idx_r + BlkAw'(1);
          end
        end
        S_LOAD: begin
          cnt_r <= cnt_at_end ? '0 : cnt_r + 6'd1;
          if (cnt_at_end) begin
            state_r <= S_ROUND;
          end
        end
        S_ROUND: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(shamh_pkg::Rounds - 1)) begin
            state_r <= S_FOLD;
          end
        end
        S_FOLD: begin
          cnt_r <= cnt_at_end ? '0 : cnt_r + 6'd1;
          if (cnt_at_end) begin
            if (!fin_r) begin
              state_r <= S_IDLE;
            end else if (len_r) begin
              state_r    <= S_EMIT_RD;
              emit_idx_r <= '0;
            end else begin
              // Length did not fit: one more block of zeros and the length.
              state_r   <= S_PAD;
              pad_idx_r <= '0;
              len_r     <= 1'b1;
            end
          end
        end
        S_EMIT_RD: begin
          state_r <= S_EMIT_WR;
        end
        S_EMIT_WR: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_word_r  <= chain_q;
            out_index_r <= 3'(emit_idx_r);
            out_last_r  <= (emit_idx_r == HashAw'(shamh_pkg::HashWords - 1));
            if (emit_idx_r == HashAw'(shamh_pkg::HashWords - 1)) begin
              state_r  <= S_IDLE;
              hv_r     <= '0;
              fill_r   <= '0;
              bitlen_r <= '0;
              fin_r    <= 1'b0;
              len_r    <= 1'b0;
            end else begin
              state_r    <= S_EMIT_RD;
              emit_idx_r <= emit_idx_r + HashAw'(1);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_index_r;
  assign out_last_word   = out_last_r;

endmodule

### design/shamh_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the SHA-256 message hasher, bound to the top level.
// Depends only on the ports of sha256_message_hasher_core.
module shamh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_end_of_message,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  // A stalled digest word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word) &&
    $stable(out_word_index))
    else $error("digest word changed while stalled");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last_word flag does not match word index");

  // Words of one digest come out in order.
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word |=>
    !out_valid || (out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest word index skipped");

  // The final item always triggers padding and compression.
  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_message |=> !in_ready)
    else $error("input accepted right after end of message");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind sha256_message_hasher_core shamh_checker u_shamh_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_end_of_message (in_end_of_message),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_digest_word   (out_digest_word),
  .out_word_index    (out_word_index),
  .out_last_word     (out_last_word)
);
